// ===== rtl/core/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants of the serial command line decoder: command
// codes, the keyword table and the item passed from front to back.
// ----------------------------------------------------------------------------
package scd_pkg;

    // Command codes as reported on the result channel
    localparam logic [3:0] CMD_START      = 4'd0;
    localparam logic [3:0] CMD_STOP       = 4'd1;
    localparam logic [3:0] CMD_LED        = 4'd2;
    localparam logic [3:0] CMD_INFER      = 4'd3;
    localparam logic [3:0] CMD_TRAIN      = 4'd4;
    localparam logic [3:0] CMD_GETWEIGHTS = 4'd5;
    localparam logic [3:0] CMD_SETWEIGHTS = 4'd6;
    localparam logic [3:0] CMD_DONE       = 4'd7;
    localparam logic [3:0] CMD_UNKNOWN    = 4'd8;

    // Item kinds
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Special characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // Keyword table, padded with zeros past each word's length
    localparam int NUM_WORDS    = 7;
    localparam int MAX_WORD_LEN = 10;
    localparam int EFF_W        = $clog2(MAX_WORD_LEN + 2);
    localparam int POS_W        = $clog2(MAX_WORD_LEN);

    localparam int W_START      = 0;
    localparam int W_STOP       = 1;
    localparam int W_LED        = 2;
    localparam int W_INFER      = 3;
    localparam int W_GETWEIGHTS = 4;
    localparam int W_SETWEIGHTS = 5;
    localparam int W_DONE       = 6;

    localparam logic [7:0] WORD_CHARS [NUM_WORDS][MAX_WORD_LEN] = '{
        '{8'h73, 8'h74, 8'h61, 8'h72, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h74, 8'h6F, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6C, 8'h65, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h6E, 8'h66, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h65, 8'h74, 8'h77, 8'h65, 8'h69, 8'h67, 8'h68, 8'h74, 8'h73},
        '{8'h73, 8'h65, 8'h74, 8'h77, 8'h65, 8'h69, 8'h67, 8'h68, 8'h74, 8'h73},
        '{8'h64, 8'h6F, 8'h6E, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [EFF_W-1:0] WORD_LENS [NUM_WORDS] = '{
        EFF_W'(5), EFF_W'(4), EFF_W'(3), EFF_W'(5), EFF_W'(10), EFF_W'(10), EFF_W'(4)
    };

    // Item carried through the queue
    typedef struct packed {
        logic       kind;
        logic [3:0] command;
        logic [1:0] label;
        logic [7:0] data;
        logic [7:0] index;
        logic       last;
    } t_token;

    // Push side of the queue
    typedef struct packed {
        logic   valid;
        t_token token;
    } t_push;

    // Queue status toward both sides
    typedef struct packed {
        logic not_full;
        logic not_empty;
    } t_q_status;

endpackage

// ===== rtl/core/scd_front.sv =====
// ----------------------------------------------------------------------------
// scd_front
// Accepts received bytes and classifies them. In line mode it tracks the
// stored length and matches the line against the keywords as bytes arrive,
// so a line end yields its command at once. In payload mode it tags bytes
// with index and last mark.
// ----------------------------------------------------------------------------
module scd_front #(
    parameter int LINE_CAPACITY  = 31,
    parameter int PAYLOAD_LENGTH = 224
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    input  scd_pkg::t_q_status  i_q_status,
    output scd_pkg::t_push      o_push
);
    import scd_pkg::*;

    localparam int LW = $clog2(LINE_CAPACITY + 1);
    localparam int CW = $clog2(PAYLOAD_LENGTH + 1);
    localparam logic [EFF_W-1:0] EFF_MAX = EFF_W'(MAX_WORD_LEN + 1);

    // Line tracking
    logic [LW-1:0]        r_len;
    logic                 r_zero_seen;
    logic [EFF_W-1:0]     r_eff;
    logic [NUM_WORDS-1:0] r_alive;
    logic                 r_l_ok;
    logic [1:0]           r_label;

    // Payload tracking
    logic                 r_payload_mode;
    logic [CW-1:0]        r_count;

    logic                 accept;
    logic                 is_end;
    logic                 store;
    logic [7:0]           lc;
    logic [POS_W-1:0]     pos;
    logic [NUM_WORDS-1:0] n_alive;
    logic                 lc_digit;
    logic [3:0]           cmd;
    logic                 last;
    logic [CW+7:0]        count_ext;

    assign o_ready = i_q_status.not_full;
    assign accept  = i_valid && o_ready;
    assign is_end  = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign store   = !is_end && (i_rx_byte != CH_SPACE) &&
                     (r_len < LW'(LINE_CAPACITY));

    // Lowercase A-Z only
    assign lc = ((i_rx_byte >= CH_UP_A) && (i_rx_byte <= CH_UP_Z)) ?
                (i_rx_byte | 8'h20) : i_rx_byte;

    assign lc_digit = (lc >= CH_0) && (lc <= CH_3);

    // Compare the new character against every keyword at the current place
    always_comb begin
        pos = (r_eff < EFF_W'(MAX_WORD_LEN)) ? r_eff[POS_W-1:0] : '0;
        for (int w = 0; w < NUM_WORDS; w++) begin
            n_alive[w] = r_alive[w] && (r_eff < WORD_LENS[w]) &&
                         (lc == WORD_CHARS[w][pos]);
        end
    end

    // Pick the command of a finished line
    always_comb begin
        priority if (r_alive[W_START] && r_eff == WORD_LENS[W_START]) begin
            cmd = CMD_START;
        end else if (r_alive[W_STOP] && r_eff == WORD_LENS[W_STOP]) begin
            cmd = CMD_STOP;
        end else if (r_alive[W_LED] && r_eff == WORD_LENS[W_LED]) begin
            cmd = CMD_LED;
        end else if (r_alive[W_INFER] && r_eff == WORD_LENS[W_INFER]) begin
            cmd = CMD_INFER;
        end else if (r_l_ok && r_eff == EFF_W'(2)) begin
            cmd = CMD_TRAIN;
        end else if (r_alive[W_GETWEIGHTS] && r_eff == WORD_LENS[W_GETWEIGHTS]) begin
            cmd = CMD_GETWEIGHTS;
        end else if (r_alive[W_SETWEIGHTS] && r_eff == WORD_LENS[W_SETWEIGHTS]) begin
            cmd = CMD_SETWEIGHTS;
        end else if (r_alive[W_DONE] && r_eff == WORD_LENS[W_DONE]) begin
            cmd = CMD_DONE;
        end else begin
            cmd = CMD_UNKNOWN;
        end
    end

    assign last      = (r_count == CW'(PAYLOAD_LENGTH - 1));
    assign count_ext = {8'b0, r_count};

    // Build the item for the queue
    always_comb begin
        o_push = '0;
        if (r_payload_mode) begin
            o_push.valid         = accept;
            o_push.token.kind    = KIND_PAYLOAD;
            o_push.token.data    = i_rx_byte;
            o_push.token.index   = count_ext[7:0];
            o_push.token.last    = last;
        end else begin
            o_push.valid         = accept && is_end && (r_len != '0);
            o_push.token.kind    = KIND_COMMAND;
            o_push.token.command = cmd;
            o_push.token.label   = (cmd == CMD_TRAIN) ? r_label : 2'd0;
        end
    end

    // Advance line and payload state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len          <= '0;
            r_zero_seen    <= 1'b0;
            r_eff          <= '0;
            r_alive        <= '1;
            r_l_ok         <= 1'b1;
            r_label        <= 2'd0;
            r_payload_mode <= 1'b0;
            r_count        <= '0;
        end else if (accept) begin
            if (r_payload_mode) begin
                if (last) begin
                    r_payload_mode <= 1'b0;
                    r_count        <= '0;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end else if (is_end) begin
                if (r_len != '0) begin
                    if (cmd == CMD_SETWEIGHTS) begin
                        r_payload_mode <= 1'b1;
                        r_count        <= '0;
                    end
                    r_len       <= '0;
                    r_zero_seen <= 1'b0;
                    r_eff       <= '0;
                    r_alive     <= '1;
                    r_l_ok      <= 1'b1;
                    r_label     <= 2'd0;
                end
            end else if (store) begin
                r_len <= r_len + LW'(1);
                if (!r_zero_seen) begin
                    if (i_rx_byte == CH_NUL) begin
                        // the line ends at its first zero byte
                        r_zero_seen <= 1'b1;
                    end else begin
                        r_alive <= n_alive;
                        if (r_eff == EFF_W'(0)) begin
                            r_l_ok <= (lc == CH_L);
                        end else if (r_eff == EFF_W'(1)) begin
                            r_l_ok  <= r_l_ok && lc_digit;
                            r_label <= lc[1:0];
                        end else begin
                            r_l_ok <= 1'b0;
                        end
                        if (r_eff != EFF_MAX) begin
                            r_eff <= r_eff + EFF_W'(1);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/scd_queue.sv =====
// ----------------------------------------------------------------------------
// scd_queue
// Two-entry queue that parts the byte front from the result back, so each
// side can stall on its own.
// ----------------------------------------------------------------------------
module scd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scd_pkg::t_push      i_push,
    input  logic                i_pop,
    output scd_pkg::t_q_status  o_status,
    output scd_pkg::t_token     o_head
);
    import scd_pkg::*;

    t_token     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.not_full  = (r_count != 2'd2);
    assign o_status.not_empty = (r_count != 2'd0);
    assign o_head             = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && o_status.not_full;
    assign do_pop  = i_pop && o_status.not_empty;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.token;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/scd_back.sv =====
// ----------------------------------------------------------------------------
// scd_back
// Takes items from the queue, carries out start and stop on the logging
// flag, and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module scd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scd_pkg::t_q_status  i_q_status,
    input  scd_pkg::t_token     i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_kind,
    output logic [3:0]          o_command,
    output logic [1:0]          o_train_label,
    output logic                o_logging_on,
    output logic [7:0]          o_payload_byte,
    output logic [7:0]          o_payload_index,
    output logic                o_payload_last
);
    import scd_pkg::*;

    logic       r_valid;
    logic       r_logging;
    t_token     r_token;
    logic       r_logging_out;
    logic       n_logging;

    assign o_pop = i_q_status.not_empty && (!r_valid || i_ready);

    // Logging flag after this item
    always_comb begin
        n_logging = r_logging;
        if (i_head.kind == KIND_COMMAND) begin
            if (i_head.command == CMD_START) begin
                n_logging = 1'b1;
            end else if (i_head.command == CMD_STOP) begin
                n_logging = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_logging <= 1'b1;
        end else begin
            if (o_pop) begin
                r_valid   <= 1'b1;
                r_logging <= n_logging;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_token       <= i_head;
            r_logging_out <= n_logging;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_token.kind;
    assign o_command       = r_token.command;
    assign o_train_label   = r_token.label;
    assign o_logging_on    = r_logging_out;
    assign o_payload_byte  = r_token.data;
    assign o_payload_index = r_token.index;
    assign o_payload_last  = r_token.last;

endmodule

// ===== rtl/core/serial_command_line_decoder.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_decoder
// Decodes command lines from a stream of received serial bytes.
//
// Input channel (i_valid / o_ready, i_rx_byte): one received byte per item.
// In line mode spaces are dropped and up to LINE_CAPACITY bytes are kept;
// CR or LF on a non-empty line yields one command result and clears the line.
// A setweights command switches to payload mode, where the next
// PAYLOAD_LENGTH bytes each yield a payload result with index and last mark.
// Output channel (o_valid / i_ready): one result per command or payload byte.
// Throughput: one byte per cycle while the queue is not full; the front
// matches keywords as bytes arrive, so a line end yields its command at
// once. Each item enters the two-entry queue at the accepting edge and
// moves to the output register once the back takes it from the queue.
// When the receiver stalls, the output register holds and the queue fills;
// o_ready drops once the queue is full. Reset empties the queue and the
// line, leaves payload mode and sets the logging flag.
// ----------------------------------------------------------------------------
module serial_command_line_decoder #(
    parameter int LINE_CAPACITY  = 31,
    parameter int PAYLOAD_LENGTH = 224
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [3:0] o_command,
    output logic [1:0] o_train_label,
    output logic       o_logging_on,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_payload_index,
    output logic       o_payload_last
);
    import scd_pkg::*;

    t_push     push;
    t_q_status q_status;
    t_token    head;
    logic      pop;

    // Classify bytes
    scd_front #(
        .LINE_CAPACITY  (LINE_CAPACITY),
        .PAYLOAD_LENGTH (PAYLOAD_LENGTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_status (q_status),
        .o_push     (push)
    );

    // Buffer items between the two sides
    scd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head)
    );

    // Carry out items and present results
    scd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_command       (o_command),
        .o_train_label   (o_train_label),
        .o_logging_on    (o_logging_on),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_payload_last  (o_payload_last)
    );

endmodule
